>>> hdl/earliest_free_worker_assign_unit_macros.svh
// assertion macros shared by the scheduler rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef EARLIEST_FREE_WORKER_ASSIGN_UNIT_MACROS_SVH
`define EARLIEST_FREE_WORKER_ASSIGN_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define EFW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efw assertion failed");

// next-cycle implication, quiet during reset
`define EFW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("efw assertion failed");

`endif

>>> hdl/efw_pkg.sv
// shared types and constants for the earliest free worker scheduler
// no dependencies
package efw_pkg;

  localparam int DEF_MAX_WORKERS = 16;
  localparam int DEF_TIME_BITS   = 48;

  localparam int DUR_W    = 32;
  localparam int WORKER_W = 4;
  localparam int START_W  = 48;
  localparam int WCOUNT_W = 5;

  localparam logic [WCOUNT_W-1:0] WCOUNT_RST = 5'd16;

  // apb register map: one register at byte 0 on a 32-bit data bus
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_WORKER_COUNT = 1'b0;

  typedef struct packed {
    logic             new_batch;
    logic [DUR_W-1:0] duration;
  } in_word_t;

  typedef struct packed {
    logic [WORKER_W-1:0] worker;
    logic [START_W-1:0]  start_time;
  } out_word_t;

  // control strobes from the sequencer to the finish time store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } efw_mem_ctl_t;

endpackage

>>> hdl/earliest_free_worker_assign_unit.sv
// top level of the earliest free worker scheduler: apb register, output register
// uses efw_pkg, efw_time_store and efw_sched
//
// Each input word carries a job duration and a new batch flag; the block picks
// the active worker whose finish time is smallest (lowest index wins a tie),
// returns that worker with its old finish time as the start time, and adds the
// duration to that finish time, saturating at 2^TIME_BITS-1. A new batch flag
// clears every finish time before the job. Register worker_count at byte 0
// sets the active workers; 0 acts as 1 and values above MAX_WORKERS act as
// MAX_WORKERS. Per job the sequencer accepts the word, then scans the n
// active workers: the single read port of the finish time memory yields one
// stored time per cycle to the one comparator, the read is registered so the
// last compare trails the last read, and the scan winds down before the
// update writes the new finish time; the result then waits until the
// output register is free. The next job is accepted while a finished result
// still waits in the output register.
// Finish times reset to zero through per-entry valid bits, so there is no
// clearing pass after reset.
module earliest_free_worker_assign_unit
  import efw_pkg::*;
#(
  parameter int MAX_WORKERS = DEF_MAX_WORKERS,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // job input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);

  logic [WCOUNT_W-1:0]  wcount_r;
  logic [CNT_W-1:0]     active_cnt;
  logic                 reg_sel;
  logic                 out_valid_r;
  out_word_t            out_data_r;
  logic                 out_free;
  logic                 res_load;
  out_word_t            res_word;
  efw_mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic [TIME_BITS-1:0] wr_data;
  logic [TIME_BITS-1:0] rd_data;

  // register decode: everything below byte 4 maps onto worker_count
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_WORKER_COUNT);
  assign prdata  = reg_sel ? CFG_DATA_W'(wcount_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcount_r <= WCOUNT_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      wcount_r <= pwdata[WCOUNT_W-1:0];
    end
  end

  // clamp the register into 1 .. MAX_WORKERS
  always_comb begin
    if (wcount_r == '0) begin
      active_cnt = CNT_W'(1);
    end else if (32'(wcount_r) > 32'(MAX_WORKERS)) begin
      active_cnt = CNT_W'(MAX_WORKERS);
    end else begin
      active_cnt = CNT_W'(wcount_r);
    end
  end

  // output register, frees in the cycle its word is taken
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res_word;
    end
  end

  efw_sched #(
    .MAX_WORKERS (MAX_WORKERS),
    .TIME_BITS   (TIME_BITS)
  ) u_sched (
    .clk        (clk),
    .rst_n      (rst_n),
    .active_cnt (active_cnt),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_free   (out_free),
    .res_load   (res_load),
    .res_word   (res_word),
    .mem_ctl    (mem_ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data)
  );

  efw_time_store #(
    .MAX_WORKERS (MAX_WORKERS),
    .TIME_BITS   (TIME_BITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

>>> hdl/efw_time_store.sv
// finish time memory, one write and one registered read port
// valid bit per entry so that reset and new batch clear at once; uses efw_pkg
module efw_time_store
  import efw_pkg::*;
#(
  parameter int MAX_WORKERS = DEF_MAX_WORKERS,
  parameter int TIME_BITS   = DEF_TIME_BITS,
  localparam int IDX_W      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  efw_mem_ctl_t         ctl,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [TIME_BITS-1:0] wr_data,
  output logic [TIME_BITS-1:0] rd_data
);

  logic [TIME_BITS-1:0]   mem [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] vld_r;
  logic [TIME_BITS-1:0]   rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        vld_r <= '0;
      end else if (ctl.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // never written since reset or batch start reads as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

>>> hdl/efw_sched.sv
// sequencer: serial minimum scan over the store, then saturating update
// uses efw_pkg and the assertion macros header
`include "earliest_free_worker_assign_unit_macros.svh"

module efw_sched
  import efw_pkg::*;
#(
  parameter int MAX_WORKERS = DEF_MAX_WORKERS,
  parameter int TIME_BITS   = DEF_TIME_BITS,
  localparam int IDX_W      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
  localparam int CNT_W      = $clog2(MAX_WORKERS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CNT_W-1:0]     active_cnt,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  input  logic                 out_free,
  output logic                 res_load,
  output out_word_t            res_word,
  output efw_mem_ctl_t         mem_ctl,
  output logic [IDX_W-1:0]     rd_addr,
  output logic [IDX_W-1:0]     wr_addr,
  output logic [TIME_BITS-1:0] wr_data,
  input  logic [TIME_BITS-1:0] rd_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     issue_cnt_r, issue_cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0] best_val_r, best_val_nxt;
  logic [DUR_W-1:0]     dur_r, dur_nxt;
  logic [TIME_BITS:0]   sum;
  logic                 accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // the one adder, used only in the update step
  assign sum     = {1'b0, best_val_r} + (TIME_BITS + 1)'(dur_r);
  assign wr_data = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign wr_addr = best_idx_r;

  assign res_word.worker     = WORKER_W'(best_idx_r);
  assign res_word.start_time = START_W'(best_val_r);

  always_comb begin
    state_nxt     = state_r;
    issue_cnt_nxt = issue_cnt_r;
    pend_nxt      = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    dur_nxt       = dur_r;
    mem_ctl       = '0;
    rd_addr       = issue_cnt_r[IDX_W-1:0];
    res_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mem_ctl.clear = in_data.new_batch;
          dur_nxt       = in_data.duration;
          issue_cnt_nxt = '0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one read a cycle, compare the word that came back
        if (issue_cnt_r < active_cnt) begin
          mem_ctl.rd_en = 1'b1;
          pend_nxt      = 1'b1;
          cmp_idx_nxt   = issue_cnt_r[IDX_W-1:0];
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = ST_UPD;
        end
        if (pend_r) begin
          if (cmp_idx_r == '0 || rd_data < best_val_r) begin
            best_idx_nxt = cmp_idx_r;
            best_val_nxt = rd_data;
          end
        end
      end
      ST_UPD: begin
        mem_ctl.wr_en = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_cnt_r <= issue_cnt_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_val_r  <= best_val_nxt;
    dur_r       <= dur_nxt;
  end

  `EFW_ASSERT_NEXT(a_accept_starts_scan, accept, state_r == ST_SCAN)
  `EFW_ASSERT_IMPL(a_issue_in_range, state_r == ST_SCAN, issue_cnt_r <= active_cnt)
  `EFW_ASSERT_IMPL(a_best_is_active, state_r == ST_UPD, best_idx_r < active_cnt)
  `EFW_ASSERT_NEXT(a_update_then_done, state_r == ST_UPD, state_r == ST_DONE)

endmodule

>>> bench/earliest_free_worker_assign_unit_test.sv
// self-checking bench for earliest_free_worker_assign_unit: directed rows
// and random phases over several worker counts; uses efw_pkg and the rtl under hdl
module earliest_free_worker_assign_unit_test;
  import efw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = DEF_MAX_WORKERS;
  localparam int TIME_W = DEF_TIME_BITS;

  // byte address of the worker count register
  localparam logic [CFG_ADDR_W-1:0] WC_ADDR = CFG_ADDR_W'({REG_WORKER_COUNT, 2'b00});

  // cycles with no word moving on either channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // receiver hold-off used once to back the block up into its input
  localparam int HOLD_CYCLES = 300;
  // settle time after the last result
  localparam int SETTLE_CYCLES = MAX_W + 8;
  localparam int RAND_PHASES = 13;
  localparam int PHASE_JOBS = 150;

  // worker counts for the first random phases: reset value, extremes, out of range
  localparam int unsigned WC_PLAN [7] = '{16, 1, 0, 31, 2, 15, 17};

  // directed stimulus row; typed rows carry a result read straight off the spec
  typedef struct packed {
    bit                  set_cfg;
    logic [WCOUNT_W-1:0] cfg;
    logic                new_batch;
    logic [DUR_W-1:0]    duration;
    bit                  typed;
    logic [WORKER_W-1:0] worker;
    logic [START_W-1:0]  start;
  } step_row_t;

  localparam int N_STEPS = 22;
  localparam step_row_t STEPS [N_STEPS] = '{
    // out of reset: 16 workers, all idle
    '{1'b0, 5'd0,  1'b0, 32'd5,          1'b1, 4'd0, 48'd0},
    '{1'b0, 5'd0,  1'b0, 32'd0,          1'b1, 4'd1, 48'd0},
    // zero-length job left worker 1 free, so it takes the longest job too
    '{1'b0, 5'd0,  1'b0, 32'hFFFF_FFFF,  1'b1, 4'd1, 48'd0},
    // new batch wipes the table
    '{1'b0, 5'd0,  1'b1, 32'd7,          1'b1, 4'd0, 48'd0},
    '{1'b0, 5'd0,  1'b0, 32'd3,          1'b1, 4'd1, 48'd0},
    // single worker: jobs queue back to back on worker 0
    '{1'b1, 5'd1,  1'b0, 32'd10,         1'b1, 4'd0, 48'd7},
    '{1'b0, 5'd0,  1'b0, 32'd1,          1'b1, 4'd0, 48'd17},
    // zero count behaves as one
    '{1'b1, 5'd0,  1'b0, 32'd2,          1'b1, 4'd0, 48'd18},
    '{1'b0, 5'd0,  1'b1, 32'd4,          1'b1, 4'd0, 48'd0},
    // 31 clamps to all sixteen workers
    '{1'b1, 5'd31, 1'b0, 32'd6,          1'b1, 4'd1, 48'd0},
    '{1'b0, 5'd0,  1'b0, 32'd100,        1'b1, 4'd2, 48'd0},
    '{1'b1, 5'd17, 1'b0, 32'hFFFF_FFFF,  1'b1, 4'd3, 48'd0},
    // two workers; workers 2 and 3 keep their times while out of the scan
    '{1'b1, 5'd2,  1'b0, 32'd1,          1'b0, 4'd0, 48'd0},
    '{1'b0, 5'd0,  1'b0, 32'd3,          1'b0, 4'd0, 48'd0},
    '{1'b0, 5'd0,  1'b0, 32'd0,          1'b0, 4'd0, 48'd0},
    '{1'b1, 5'd16, 1'b0, 32'd1,          1'b0, 4'd0, 48'd0},
    '{1'b0, 5'd0,  1'b0, 32'hFFFF_FFFF,  1'b0, 4'd0, 48'd0},
    '{1'b1, 5'd15, 1'b0, 32'd0,          1'b0, 4'd0, 48'd0},
    '{1'b1, 5'd16, 1'b1, 32'hFFFF_FFFF,  1'b1, 4'd0, 48'd0},
    '{1'b0, 5'd0,  1'b1, 32'd0,          1'b1, 4'd0, 48'd0},
    '{1'b0, 5'd0,  1'b0, 32'hAAAA_AAAA,  1'b0, 4'd0, 48'd0},
    '{1'b0, 5'd0,  1'b0, 32'h5555_5555,  1'b0, 4'd0, 48'd0}
  };

  typedef struct {
    bit        typed;
    out_word_t want;
  } job_hint_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow of the block: worker count register and per-worker finish times
  logic [WCOUNT_W-1:0]   worker_cnt = WCOUNT_RST;
  logic [TIME_W-1:0]     finish_at [MAX_W];

  out_word_t             results_due [$];
  job_hint_t             hint_q [$];

  bit                    tx_idle = 1'b1;
  bit                    rx_idle = 1'b1;
  bit                    hold_req = 1'b0;

  int unsigned           quiet_cycles = 0;
  int unsigned           fail_count = 0;
  int unsigned           jobs_seen = 0;
  int unsigned           results_checked = 0;
  int unsigned           cfg_writes = 0;
  int unsigned           sat_hits = 0;

  earliest_free_worker_assign_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // greedy placement: optional wipe, lowest finish time among active workers
  // (first index wins a tie), then saturating add of the duration
  function automatic out_word_t place_job(input in_word_t job);
    int unsigned         n;
    int unsigned         best;
    logic [TIME_W:0]     sum;
    out_word_t           res;
    n = (worker_cnt == 0) ? 1 : ((worker_cnt > MAX_W) ? MAX_W : worker_cnt);
    if (job.new_batch) begin
      foreach (finish_at[k]) finish_at[k] = '0;
    end
    best = 0;
    for (int unsigned j = 1; j < n; j++) begin
      if (finish_at[j] < finish_at[best]) best = j;
    end
    res.worker = best[WORKER_W-1:0];
    res.start_time = finish_at[best];
    sum = {1'b0, finish_at[best]} + (TIME_W+1)'(job.duration);
    if (sum[TIME_W]) begin
      // clamp at the top of the time range
      finish_at[best] = '1;
      sat_hits++;
    end else begin
      finish_at[best] = sum[TIME_W-1:0];
    end
    return res;
  endfunction

  // mostly short jobs so ties and small start times are common,
  // with full-range and maximum lengths mixed in
  function automatic in_word_t random_job();
    in_word_t job;
    job.new_batch = ($urandom_range(0, 24) == 0);
    case ($urandom_range(0, 9))
      0: begin
        job.duration = '0;
      end
      1: begin
        job.duration = '1;
      end
      2, 3, 4: begin
        job.duration = $urandom_range(0, 15);
      end
      5, 6: begin
        job.duration = $urandom_range(0, 4000);
      end
      default: begin
        job.duration = $urandom;
      end
    endcase
    return job;
  endfunction

  // sampling monitor: model update on every accepted job, result compare,
  // register shadow and the hang watchdog all run off the same edge
  always @(posedge clk) begin
    job_hint_t hint;
    out_word_t want;
    if (!rst_n) begin
      worker_cnt = WCOUNT_RST;
      foreach (finish_at[k]) finish_at[k] = '0;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (psel && penable && pwrite && pready && paddr == WC_ADDR) begin
        worker_cnt = pwdata[WCOUNT_W-1:0];
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        hint = hint_q.pop_front();
        want = place_job(in_data);
        // typed rows take their hand-written value over the model's
        if (hint.typed) want = hint.want;
        results_due.push_back(want);
        jobs_seen++;
        quiet_cycles = 0;
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (results_due.size() == 0) begin
          $error("result with no job pending: worker %0d start_time %0d",
                 out_data.worker, out_data.start_time);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (out_data.worker !== want.worker) begin
            $error("worker: expected %0d, got %0d", want.worker, out_data.worker);
            fail_count++;
          end
          if (out_data.start_time !== want.start_time) begin
            $error("start_time: expected %0d, got %0d",
                   want.start_time, out_data.start_time);
            fail_count++;
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, results_due.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // offer one job; valid stays up across back-to-back jobs
  task automatic offer_job(input in_word_t job, input bit typed, input out_word_t want);
    int unsigned gap;
    job_hint_t   hint;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    hint.typed = typed;
    hint.want = want;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hint_q.push_back(hint);
    in_valid <= 1'b1;
    in_data <= job;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering, let every result come back and the scan wind down;
  // one edge first so the monitor has queued the last accepted job
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup then access; upper data bits carry noise the register drops
  task automatic write_worker_count(input logic [WCOUNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = $urandom;
    wdata[WCOUNT_W-1:0] = count;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WC_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // result side: random back-pressure per word, plus one long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 7) : 0;
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    in_word_t  job;
    out_word_t want;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; count changes only with the block drained
    foreach (STEPS[i]) begin
      if (STEPS[i].set_cfg) begin
        settle();
        write_worker_count(STEPS[i].cfg);
      end
      job.new_batch = STEPS[i].new_batch;
      job.duration = STEPS[i].duration;
      want.worker = STEPS[i].worker;
      want.start_time = STEPS[i].start;
      offer_job(job, STEPS[i].typed, want);
    end

    // random phases over fixed extremes first, then random counts
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      if (p < 7) begin
        write_worker_count(WCOUNT_W'(WC_PLAN[p]));
      end else begin
        write_worker_count(WCOUNT_W'($urandom_range(0, 31)));
      end
      // one phase runs flat out on both sides
      tx_idle = (p != 5);
      rx_idle = (p != 5);
      // one phase backs results up while jobs keep coming
      if (p == 3) hold_req = 1'b1;
      for (int k = 0; k < PHASE_JOBS; k++) begin
        offer_job(random_job(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d jobs through %0d worker count writes, %0d saturated finish times",
             jobs_seen, cfg_writes, sat_hits);
    $display("compared %0d results, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/efw_pkg.sv
hdl/efw_time_store.sv
hdl/efw_sched.sv
hdl/earliest_free_worker_assign_unit.sv
bench/earliest_free_worker_assign_unit_test.sv
